// ===== src/oaid_pkg.sv =====
// Shared types and codes for the ordered array insert/delete unit.
// No dependencies; used by every module under src/.
package oaid_pkg;

  // operation codes on the input beat
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_EDIT   = 3'd3;
  localparam logic [2:0] OP_VIEW   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BADINDEX = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam int POS_W = 4;
  localparam int CNT_W = 4;

  typedef struct packed {
    logic [2:0]       operation;
    logic [POS_W-1:0] position;
    logic signed [31:0] data_in;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] fill_count;
    logic signed [31:0] data_out;
    logic             last;
  } result_t;

  typedef enum logic [2:0] {
    KIND_APPEND,
    KIND_INSERT,
    KIND_DELETE,
    KIND_EDIT,
    KIND_VIEW
  } kind_t;

  // classified command, front to back
  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] position;
    logic signed [31:0] data_in;
  } cmd_t;

endpackage

// ===== src/ordered_array_insert_delete_unit.sv =====
// Ordered array unit: an accepted start is written into the command queue, and the back end
// registers the done beat of an update; a view gives its elements one per cycle once popped.
// Throughput: one update per cycle while no view streams; a view holds the back end until its
// last element, and busy rises once the command queue (QUEUE_DEPTH entries) fills behind it.
// Reset (rst, synchronous): empties the array and the queue; stored words are not cleared.
// Results are one-cycle done beats; the receiver cannot stall them.
module ordered_array_insert_delete_unit #(
  parameter int DEPTH       = 8,  // array capacity, 1 to 15
  parameter int QUEUE_DEPTH = 2   // command queue entries, power of two
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  oaid_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output oaid_pkg::result_t result
);

  // front to queue
  logic           push;
  oaid_pkg::cmd_t  push_cmd;
  logic           q_full;

  // queue to back
  oaid_pkg::cmd_t  head;
  logic           q_empty;
  logic           pop;

  // Front: a beat is taken whenever the queue has room. Unused opcodes are
  // swallowed here, so they never reach the back end and give no result.
  oaid_front u_front (
    .start  (start),
    .item   (item),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .cmd    (push_cmd)
  );

  // Queue: decouples acceptance from the view streaming in the back end.
  oaid_queue #(
    .ENTRIES (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: checks against the fill count, shifts all cells at once on
  // insert/delete, and walks the cells one per cycle for a view.
  oaid_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== src/oaid_front.sv =====
// Front end: takes input beats, drops unused operation codes, classifies the rest.
// Depends on oaid_pkg.
module oaid_front (
  input  logic           start,
  input  oaid_pkg::item_t item,
  input  logic           q_full,
  output logic           busy,
  output logic           push,
  output oaid_pkg::cmd_t  cmd
);

  logic known;

  always_comb begin
    known    = 1'b1;
    cmd.kind = oaid_pkg::KIND_VIEW;
    unique case (item.operation)
      oaid_pkg::OP_APPEND: cmd.kind = oaid_pkg::KIND_APPEND;
      oaid_pkg::OP_INSERT: cmd.kind = oaid_pkg::KIND_INSERT;
      oaid_pkg::OP_DELETE: cmd.kind = oaid_pkg::KIND_DELETE;
      oaid_pkg::OP_EDIT:   cmd.kind = oaid_pkg::KIND_EDIT;
      oaid_pkg::OP_VIEW:   cmd.kind = oaid_pkg::KIND_VIEW;
      default:             known    = 1'b0;  // accepted, no effect
    endcase
    cmd.position = item.position;
    cmd.data_in  = item.data_in;
  end

  assign busy = q_full;
  assign push = start && !q_full && known;

endmodule

// ===== src/oaid_queue.sv =====
// Small command queue between front and back, show-ahead read.
// Depends on oaid_pkg. ENTRIES must be a power of two, at least 2.
module oaid_queue #(
  parameter int ENTRIES = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  oaid_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output oaid_pkg::cmd_t  head,
  output logic           empty,
  output logic           full
);

  localparam int PW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  oaid_pkg::cmd_t slots [ENTRIES];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [LW-1:0]  level;

  assign empty = (level == '0);
  assign full  = (level == LW'(ENTRIES));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

// ===== src/oaid_back.sv =====
// Back end: element cells with parallel shift, fill count, status checks and view streaming.
// Depends on oaid_pkg.
module oaid_back #(
  parameter int DEPTH = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  oaid_pkg::cmd_t   head,
  input  logic            q_empty,
  output logic            pop,
  output logic            done,
  output oaid_pkg::result_t result
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > oaid_pkg::POS_W) ? CW : oaid_pkg::POS_W;

  typedef enum logic {
    S_IDLE,
    S_VIEW
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INS,
    ACT_DEL,
    ACT_EDIT
  } act_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [IW-1:0]       idx;
  logic signed [31:0]  cells      [DEPTH];
  logic signed [31:0]  cells_next [DEPTH];

  logic [CMPW-1:0]     cnt_x;
  logic [CMPW-1:0]     pos_x;
  logic [CMPW-1:0]     tgt;
  logic                is_full;
  logic                is_empty;
  logic [1:0]          st;
  act_t                act;
  act_t                act_eff;
  logic                view_go;
  logic                view_last;

  assign pop      = (state == S_IDLE) && !q_empty;
  assign cnt_x    = CMPW'(count);
  assign pos_x    = CMPW'(head.position);
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign view_last = ((CW'(idx) + CW'(1)) == count);

  // status and action for the command at the queue head
  always_comb begin
    st      = oaid_pkg::ST_OK;
    act     = ACT_NONE;
    tgt     = pos_x;
    view_go = 1'b0;
    unique case (head.kind)
      oaid_pkg::KIND_APPEND: begin
        tgt = cnt_x;
        if (is_full) st = oaid_pkg::ST_OVERFLOW;
        else         act = ACT_INS;
      end
      oaid_pkg::KIND_INSERT: begin
        priority if (is_full)       st  = oaid_pkg::ST_OVERFLOW;
        else if (pos_x > cnt_x)     st  = oaid_pkg::ST_BADINDEX;
        else                        act = ACT_INS;
      end
      oaid_pkg::KIND_DELETE: begin
        priority if (is_empty)      st  = oaid_pkg::ST_EMPTY;
        else if (pos_x >= cnt_x)    st  = oaid_pkg::ST_BADINDEX;
        else                        act = ACT_DEL;
      end
      oaid_pkg::KIND_EDIT: begin
        if (pos_x >= cnt_x) st  = oaid_pkg::ST_BADINDEX;
        else                act = ACT_EDIT;
      end
      oaid_pkg::KIND_VIEW: begin
        if (is_empty) st      = oaid_pkg::ST_EMPTY;
        else          view_go = 1'b1;
      end
      default: st = oaid_pkg::ST_OK;
    endcase
  end

  assign act_eff = pop ? act : ACT_NONE;

  always_comb begin
    unique case (act_eff)
      ACT_INS:  count_next = count + CW'(1);
      ACT_DEL:  count_next = count - CW'(1);
      default:  count_next = count;
    endcase
  end

  // every cell picks its neighbor, the new value or itself; all cells update together
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] from_below;
    logic signed [31:0] from_above;
    logic [CMPW-1:0]    here;

    assign here = CMPW'(i);
    if (i > 0) begin : g_lo
      assign from_below = cells[i-1];
    end else begin : g_lo0
      assign from_below = cells[i];
    end
    if (i < DEPTH - 1) begin : g_hi
      assign from_above = cells[i+1];
    end else begin : g_hiN
      assign from_above = cells[i];
    end

    assign cells_next[i] =
        (act_eff == ACT_INS  && here >  tgt) ? from_below :
        (act_eff == ACT_INS  && here == tgt) ? head.data_in :
        (act_eff == ACT_DEL  && here >= tgt) ? from_above :
        (act_eff == ACT_EDIT && here == tgt) ? head.data_in :
        cells[i];
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      done  <= 1'b0;
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (view_go) begin
              state <= S_VIEW;
              idx   <= '0;
            end else begin
              done              <= 1'b1;
              result.status     <= st;
              result.fill_count <= oaid_pkg::CNT_W'(count_next);
              result.data_out   <= '0;
              result.last       <= 1'b1;
            end
          end
        end
        S_VIEW: begin
          done              <= 1'b1;
          result.status     <= oaid_pkg::ST_OK;
          result.fill_count <= oaid_pkg::CNT_W'(count);
          result.data_out   <= cells[idx];
          result.last       <= view_last;
          if (view_last) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_view_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_VIEW |-> count != '0)
    else $error("streaming view of an empty array");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    done && result.status != oaid_pkg::ST_OK |-> result.last)
    else $error("error status on a non-final beat");

  a_view_contig: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done && $stable(count))
    else $error("view stream broken or count moved mid-stream");

endmodule
